### rtl/kmv_pkg.sv
`default_nettype none

package kmv_pkg;

   localparam int PRICE_W = 12;
   localparam int VALUE_W = 10;
   localparam int BUDGET_W = 12;
   localparam int BEST_W = 20;

   // Wide enough for any row index, any price and any budget.
   localparam int XW = 18;

   localparam int DEF_CAPACITY = 4096;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 12'hFFF;
   localparam logic [BEST_W-1:0] BEST_MAX = 20'hFFFFF;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [VALUE_W-1:0] value;
      logic last;
   } item_type;

endpackage

`default_nettype wire

### rtl/kmv_front.sv
`default_nettype none

module kmv_front #(
   parameter int CAPACITY = kmv_pkg::DEF_CAPACITY
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [kmv_pkg::PRICE_W-1:0] req_price,
   input wire logic [kmv_pkg::VALUE_W-1:0] req_value,
   input wire logic req_last_item,
   output logic out_valid,
   input wire logic out_ready,
   output kmv_pkg::item_type out_item
);

   localparam int XW = kmv_pkg::XW;
   localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

   logic f_vld_ff, f_vld_in;
   kmv_pkg::item_type f_item_ff, f_item_in;
   logic accept, fits, keep;

   // An object that cannot fit and does not end the problem changes nothing,
   // so it is dropped here.
   always_comb begin
      fits = XW'(req_price) < CAP_X;
      keep = fits || req_last_item;
      req_ready = !f_vld_ff || out_ready;
      accept = req_valid && req_ready;
      f_vld_in = f_vld_ff;
      f_item_in = f_item_ff;
      if (out_ready) begin
         f_vld_in = 1'b0;
      end
      if (accept && keep) begin
         f_vld_in = 1'b1;
         f_item_in.price = req_price;
         f_item_in.value = req_value;
         f_item_in.last = req_last_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= f_vld_in;
      end
      f_item_ff <= f_item_in;
   end

   assign out_valid = f_vld_ff;
   assign out_item = f_item_ff;

endmodule

`default_nettype wire

### rtl/kmv_queue.sv
`default_nettype none

module kmv_queue #(
   parameter int DEPTH = kmv_pkg::QUEUE_DEPTH
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic wr_valid,
   output logic wr_ready,
   input wire kmv_pkg::item_type wr_item,
   output logic rd_valid,
   input wire logic rd_ready,
   output kmv_pkg::item_type rd_item
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);
   localparam logic [NW-1:0] FULL_N = NW'(DEPTH);
   localparam logic [PW-1:0] LAST_P = PW'(DEPTH - 1);

   kmv_pkg::item_type slot_ff [DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [NW-1:0] n_ff, n_in;
   logic push, pop;

   always_comb begin
      wr_ready = n_ff != FULL_N;
      rd_valid = n_ff != '0;
      push = wr_valid && wr_ready;
      pop = rd_valid && rd_ready;
      wp_in = wp_ff;
      rp_in = rp_ff;
      n_in = n_ff;
      if (push) begin
         wp_in = (wp_ff == LAST_P) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == LAST_P) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) begin
         n_in = n_ff + 1'b1;
      end else if (pop && !push) begin
         n_in = n_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         n_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         n_ff <= n_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= wr_item;
      end
   end

   assign rd_item = slot_ff[rp_ff];

endmodule

`default_nettype wire

### rtl/kmv_back.sv
`default_nettype none

module kmv_back #(
   parameter int CAPACITY = kmv_pkg::DEF_CAPACITY
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic q_valid,
   output logic q_ready,
   input wire kmv_pkg::item_type q_item,
   input wire logic [kmv_pkg::BUDGET_W-1:0] budget,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [kmv_pkg::BEST_W-1:0] rsp_best_value
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int XW = kmv_pkg::XW;
   localparam int BW = kmv_pkg::BEST_W;
   localparam logic [XW-1:0] LAST_X = XW'(CAPACITY - 1);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE = 4'b0010,
      ST_SWEEP = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] c_ff, c_in;
   kmv_pkg::item_type it_ff, it_in;

   logic [BW-1:0] row_mem [CAPACITY];
   logic [BW-1:0] rd_hi_ff, rd_lo_ff;

   logic p_vld_ff, p_upd_ff, p_last_ff, p_cap_ff;
   logic [AW-1:0] p_addr_ff;
   logic [kmv_pkg::VALUE_W-1:0] p_value_ff;

   logic [BW-1:0] cap_ff, cap_in;
   logic rsp_vld_ff, rsp_vld_in;
   logic [BW-1:0] rsp_val_ff, rsp_val_in;

   logic [XW-1:0] c_x, price_x, budget_x, bsel_x, diff_x;
   logic [AW-1:0] bsel, ra_lo;
   logic upd, issue, sweep_end, load_rsp;
   logic [BW:0] take_x;
   logic [BW-1:0] take, newval, wd;
   logic we;
   logic [AW-1:0] wa;

   always_comb begin
      c_x = XW'(c_ff);
      price_x = XW'(it_ff.price);
      budget_x = XW'(budget);
      bsel_x = (budget_x > LAST_X) ? LAST_X : budget_x;
      bsel = bsel_x[AW-1:0];
      diff_x = c_x - price_x;
      upd = c_x >= price_x;
      ra_lo = upd ? diff_x[AW-1:0] : c_ff;
      issue = state_ff == ST_SWEEP;
      sweep_end = it_ff.last ? (c_ff == '0) : (c_x == price_x);

      take_x = {1'b0, rd_lo_ff} + (BW + 1)'(p_value_ff);
      take = (take_x > {1'b0, kmv_pkg::BEST_MAX}) ? kmv_pkg::BEST_MAX : take_x[BW-1:0];
      newval = (p_upd_ff && (take > rd_hi_ff)) ? take : rd_hi_ff;

      // Zeroes the row after reset and behind the final sweep, for the next problem.
      if (state_ff == ST_CLEAR) begin
         we = 1'b1;
         wa = c_ff;
         wd = '0;
      end else begin
         we = p_vld_ff && (p_upd_ff || p_last_ff);
         wa = p_addr_ff;
         wd = p_last_ff ? '0 : newval;
      end
      cap_in = (p_vld_ff && p_cap_ff) ? newval : cap_ff;
   end

   always_comb begin
      state_in = state_ff;
      c_in = c_ff;
      it_in = it_ff;
      q_ready = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            if (c_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               c_in = c_ff - 1'b1;
            end
         end
         ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               it_in = q_item;
               c_in = LAST_X[AW-1:0];
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (sweep_end) begin
               state_in = it_ff.last ? ST_RESULT : ST_IDLE;
            end else begin
               c_in = c_ff - 1'b1;
            end
         end
         ST_RESULT: begin
            if (!p_vld_ff && (!rsp_vld_ff || rsp_ready)) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            c_in = LAST_X[AW-1:0];
         end
      endcase
      rsp_vld_in = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_vld_ff);
      rsp_val_in = load_rsp ? cap_ff : rsp_val_ff;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         row_mem[wa] <= wd;
      end
      rd_hi_ff <= row_mem[c_ff];
      rd_lo_ff <= row_mem[ra_lo];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         c_ff <= LAST_X[AW-1:0];
         p_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         c_ff <= c_in;
         p_vld_ff <= issue;
         rsp_vld_ff <= rsp_vld_in;
      end
      it_ff <= it_in;
      p_upd_ff <= upd;
      p_last_ff <= it_ff.last;
      p_cap_ff <= c_ff == bsel;
      p_addr_ff <= c_ff;
      p_value_ff <= it_ff.value;
      cap_ff <= cap_in;
      rsp_val_ff <= rsp_val_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_best_value = rsp_val_ff;

endmodule

`default_nettype wire

### rtl/knapsack_01_max_value_top.sv
// A 0/1 knapsack engine. Each req beat is one object; the block keeps a row of
// CAPACITY best values and sweeps it from the top entry down to the object's
// price, one read-modify-write per cycle on the row memory's single write port.
// An object that cannot fit and is not last takes none of the back end's time.
// The last object of a problem sweeps the whole row, picks off the answer at
// the budget and zeroes the row behind it, then waits while an earlier rsp
// beat is still held. After reset the block clears the row before it starts
// on objects; req beats are still taken into a short queue meanwhile. The rsp
// beat gives the best total value within the budget that is in force when the
// last object's sweep passes the budget's entry of the row.
`default_nettype none

module knapsack_01_max_value_top #(
   parameter int CAPACITY = kmv_pkg::DEF_CAPACITY
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [kmv_pkg::PRICE_W-1:0] req_price,
   input wire logic [kmv_pkg::VALUE_W-1:0] req_value,
   input wire logic req_last_item,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [kmv_pkg::BEST_W-1:0] rsp_best_value,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [kmv_pkg::BUDGET_W-1:0] csr_budget
);

   logic [kmv_pkg::BUDGET_W-1:0] budget_ff, budget_in;
   logic f_valid, f_ready, b_valid, b_ready;
   kmv_pkg::item_type f_item, b_item;

   always_comb begin
      csr_ready = 1'b1;
      budget_in = (csr_valid && csr_ready) ? csr_budget : budget_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= kmv_pkg::BUDGET_RESET;
      end else begin
         budget_ff <= budget_in;
      end
   end

   kmv_front #(
      .CAPACITY(CAPACITY)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_price(req_price),
      .req_value(req_value),
      .req_last_item(req_last_item),
      .out_valid(f_valid),
      .out_ready(f_ready),
      .out_item(f_item)
   );

   kmv_queue #(
      .DEPTH(kmv_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .wr_valid(f_valid),
      .wr_ready(f_ready),
      .wr_item(f_item),
      .rd_valid(b_valid),
      .rd_ready(b_ready),
      .rd_item(b_item)
   );

   kmv_back #(
      .CAPACITY(CAPACITY)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(b_valid),
      .q_ready(b_ready),
      .q_item(b_item),
      .budget(budget_ff),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_best_value(rsp_best_value)
   );

endmodule

`default_nettype wire

### dv/knapsack_01_max_value_top_test.sv
`default_nettype none

module knapsack_01_max_value_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import kmv_pkg::*;

   localparam int CAPACITY = DEF_CAPACITY;
   localparam int ROW_SETTLE = CAPACITY + 16;
   localparam int QUEUE_SETTLE = (QUEUE_DEPTH + 2) * (CAPACITY + 2) + 16;
   localparam int WATCHDOG_LIMIT = 4 * QUEUE_SETTLE;
   localparam int LONG_PROBLEM = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic [PRICE_W-1:0] req_price = '0;
   logic [VALUE_W-1:0] req_value = '0;
   logic req_last_item = 1'b0;

   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [BEST_W-1:0] rsp_best_value;

   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [BUDGET_W-1:0] csr_budget = '0;

   item_type pending_objects[$];
   logic [BUDGET_W-1:0] budget_writes[$];
   logic [BEST_W-1:0] expected_best[$];

   logic [BEST_W-1:0] kept_best[CAPACITY];
   logic [BUDGET_W-1:0] budget_setting = BUDGET_RESET;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   knapsack_01_max_value_top #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_price(req_price),
      .req_value(req_value),
      .req_last_item(req_last_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_best_value(rsp_best_value),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_budget(csr_budget)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   // Sweeps the kept row downward so that each object is counted at most once.
   task automatic absorb_object(input logic [PRICE_W-1:0] price,
                                input logic [VALUE_W-1:0] value,
                                input logic last);
      logic [BEST_W:0] take;
      int spot;
      for (int c = CAPACITY - 1; c >= int'(price); c--) begin
         take = {1'b0, kept_best[c - int'(price)]} + value;
         if (take > {1'b0, BEST_MAX}) begin
            take = {1'b0, BEST_MAX};
         end
         if (take[BEST_W-1:0] > kept_best[c]) begin
            kept_best[c] = take[BEST_W-1:0];
         end
      end
      if (last) begin
         spot = (int'(budget_setting) >= CAPACITY) ? CAPACITY - 1 : int'(budget_setting);
         expected_best.push_back(kept_best[spot]);
         foreach (kept_best[i]) begin
            kept_best[i] = '0;
         end
      end
   endtask

   function automatic item_type make_object(input int price, input int value, input bit last);
      item_type obj;
      obj.price = PRICE_W'(price);
      obj.value = VALUE_W'(value);
      obj.last = last;
      return obj;
   endfunction

   always @(posedge clock) begin : driver
      item_type upcoming;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         foreach (kept_best[i]) begin
            kept_best[i] = '0;
         end
         budget_setting = BUDGET_RESET;
      end else begin
         if (req_valid && req_ready) begin
            absorb_object(req_price, req_value, req_last_item);
         end
         if (!req_valid || req_ready) begin
            if (pending_objects.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               upcoming = pending_objects.pop_front();
               req_valid <= 1'b1;
               req_price <= upcoming.price;
               req_value <= upcoming.value;
               req_last_item <= upcoming.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (csr_valid && csr_ready) begin
            budget_setting = csr_budget;
         end
         if (!csr_valid || csr_ready) begin
            if (budget_writes.size() != 0) begin
               csr_valid <= 1'b1;
               csr_budget <= budget_writes.pop_front();
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      logic [BEST_W-1:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_best.size() == 0) begin
               report_mismatch($sformatf("best_value %0d with no problem outstanding",
                                         rsp_best_value));
            end else begin
               want = expected_best.pop_front();
               if (rsp_best_value !== want) begin
                  report_mismatch($sformatf("best_value %0d, predicted %0d",
                                            rsp_best_value, want));
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic settle(input int cycles);
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_all_taken();
      while (pending_objects.size() != 0 || req_valid) @(negedge clock);
   endtask

   task automatic finish_problems();
      wait_all_taken();
      while (expected_best.size() != 0) @(negedge clock);
      settle(ROW_SETTLE);
   endtask

   task automatic write_budget(input int budget);
      budget_writes.push_back(BUDGET_W'(budget));
      @(negedge clock);
      while (budget_writes.size() != 0 || csr_valid) @(negedge clock);
   endtask

   task automatic queue_random_problems(input int problems, input int budget);
      item_type obj;
      int length;
      for (int p = 0; p < problems; p++) begin
         length = $urandom_range(1, 6);
         for (int k = 0; k < length; k++) begin
            case ($urandom_range(3))
               0: obj.price = PRICE_W'($urandom_range(63));
               1: obj.price = PRICE_W'($urandom_range(budget));
               default: obj.price = PRICE_W'($urandom);
            endcase
            obj.value = ($urandom_range(7) == 0) ? VALUE_W'(1023) : VALUE_W'($urandom);
            obj.last = (k == length - 1);
            pending_objects.push_back(obj);
         end
      end
   endtask

   initial begin : stimulus
      int idle_plan[4][2];
      int phase_budget;
      idle_plan = '{'{0, 0}, '{62, 0}, '{0, 62}, '{20, 20}};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      pending_objects.push_back(make_object(0, 1023, 1'b1));
      pending_objects.push_back(make_object(4095, 1023, 1'b0));
      pending_objects.push_back(make_object(4095, 1, 1'b1));
      pending_objects.push_back(make_object(0, 0, 1'b1));
      finish_problems();

      write_budget(10);
      pending_objects.push_back(make_object(5, 10, 1'b0));
      pending_objects.push_back(make_object(4, 40, 1'b0));
      pending_objects.push_back(make_object(6, 30, 1'b0));
      pending_objects.push_back(make_object(3, 50, 1'b1));
      pending_objects.push_back(make_object(3, 300, 1'b0));
      pending_objects.push_back(make_object(8, 500, 1'b0));
      // The budget moves while a problem is open; the new one must decide the answer.
      wait_all_taken();
      settle(QUEUE_SETTLE);
      write_budget(11);
      pending_objects.push_back(make_object(0, 1, 1'b1));
      finish_problems();

      write_budget(0);
      pending_objects.push_back(make_object(0, 7, 1'b0));
      pending_objects.push_back(make_object(1, 1000, 1'b0));
      pending_objects.push_back(make_object(0, 5, 1'b1));
      pending_objects.push_back(make_object(2, 100, 1'b0));
      pending_objects.push_back(make_object(4095, 1023, 1'b1));
      finish_problems();

      // A run of free objects, each of which lands on every entry of the row.
      write_budget(4095);
      for (int k = 0; k < LONG_PROBLEM; k++) begin
         pending_objects.push_back(make_object(0, 1023, k == LONG_PROBLEM - 1));
      end
      finish_problems();

      for (int ph = 0; ph < 4; ph++) begin
         sender_idle_pct = idle_plan[ph][0];
         receiver_stall_pct = idle_plan[ph][1];
         case (ph)
            1: phase_budget = 4095;
            2: phase_budget = $urandom_range(200);
            default: phase_budget = $urandom_range(4095);
         endcase
         write_budget(phase_budget);
         queue_random_problems(8, phase_budget);
         finish_problems();
      end

      if (mismatches == 0 && expected_best.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
